// File: sv/input_debounce_change_reporter_top_assert.svh
// assertion macros shared by the rtl files
`ifndef INPUT_DEBOUNCE_CHANGE_REPORTER_TOP_ASSERT_SVH
`define INPUT_DEBOUNCE_CHANGE_REPORTER_TOP_ASSERT_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define AST_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// condition must never be seen outside reset
`define AST_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define AST_CLK(label, clk, rst, prop)
`define AST_NEVER(label, clk, rst, cond)

`endif

`endif

// File: sv/idcr_pkg.sv
package idcr_pkg;

   // button pins are bits 0-15 and bit 20
   localparam logic [20:0] BUTTON_MASK = 21'h10FFFF;

   localparam int DEBOUNCE_DEPTH_DEF = 5;

   // csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_IDX_ANALOG  = 1'b0;
   localparam logic [0:0] CSR_IDX_ENCODER = 1'b1;

   typedef struct packed {
      logic [20:0]        pin_levels;
      logic [11:0]        analog_a;
      logic [11:0]        analog_b;
      logic [11:0]        analog_c;
      logic signed [31:0] angle_a;
      logic signed [31:0] angle_b;
   } req_type;

   typedef struct packed {
      logic               send_now;
      logic [20:0]        buttons_held;
      logic [11:0]        analog_out_a;
      logic [11:0]        analog_out_b;
      logic [11:0]        analog_out_c;
      logic signed [31:0] angle_out_a;
      logic signed [31:0] angle_out_b;
      logic signed [31:0] delta_out_a;
      logic signed [31:0] delta_out_b;
   } rsp_type;

   typedef struct packed {
      logic [1:0] analog_count;
      logic [1:0] encoder_count;
   } cfg_type;

endpackage

// File: sv/idcr_ring.sv
`include "input_debounce_change_reporter_top_assert.svh"

module idcr_ring
   import idcr_pkg::*;
#(
   parameter int DEBOUNCE_DEPTH = DEBOUNCE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [20:0] pin_levels,
   output logic [20:0] held
);

   localparam int SLOT_W = (DEBOUNCE_DEPTH > 1) ? $clog2(DEBOUNCE_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DEBOUNCE_DEPTH - 1);

   logic [20:0]       ring_ff [DEBOUNCE_DEPTH];
   logic [20:0]       ring_in [DEBOUNCE_DEPTH];
   logic [20:0]       ring_wr [DEBOUNCE_DEPTH];
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   logic [20:0]       buttons;

   // active-low pins to pressed buttons
   assign buttons = (~pin_levels) & BUTTON_MASK;

   // ring with the current sample written in
   always_comb begin
      ring_wr = ring_ff;
      ring_wr[slot_ff] = buttons;
   end

   // a press in any slot holds the button
   always_comb begin
      held = '0;
      for (int i = 0; i < DEBOUNCE_DEPTH; i++) begin
         held = held | ring_wr[i];
      end
   end

   // commit on each beat
   always_comb begin
      ring_in = advance ? ring_wr : ring_ff;
      slot_in = slot_ff;
      if (advance) begin
         slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEBOUNCE_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         slot_ff <= '0;
      end else begin
         ring_ff <= ring_in;
         slot_ff <= slot_in;
      end
   end

   `AST_CLK(a_slot_range, clock, reset, slot_ff <= SLOT_LAST)
   `AST_CLK(a_press_passes, clock, reset, advance |-> ((held & buttons) == buttons))
   `AST_CLK(a_slot_wrap, clock, reset, (advance && slot_ff == SLOT_LAST) |=> slot_ff == '0)

endmodule

// File: sv/idcr_report.sv
`include "input_debounce_change_reporter_top_assert.svh"

module idcr_report
   import idcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  cfg_type     cfg,
   input  req_type     req,
   input  logic [20:0] held,
   output rsp_type     rsp
);

   logic [20:0] sent_buttons_ff;
   logic [20:0] sent_buttons_in;
   logic [11:0] sent_analogs_ff [3];
   logic [11:0] sent_analogs_in [3];
   logic [31:0] sent_angles_ff [2];
   logic [31:0] sent_angles_in [2];

   logic [2:0]  an_en;
   logic [1:0]  enc_en;
   logic [11:0] an [3];
   logic [31:0] ang [2];
   logic [31:0] dl [2];
   logic        send;

   // channel enables from the counts, encoder count saturates at two
   assign an_en[0]  = (cfg.analog_count != 2'd0);
   assign an_en[1]  = (cfg.analog_count >= 2'd2);
   assign an_en[2]  = (cfg.analog_count == 2'd3);
   assign enc_en[0] = (cfg.encoder_count != 2'd0);
   assign enc_en[1] = (cfg.encoder_count >= 2'd2);

   // masked channels and wrapping deltas
   always_comb begin
      an[0]  = an_en[0] ? req.analog_a : '0;
      an[1]  = an_en[1] ? req.analog_b : '0;
      an[2]  = an_en[2] ? req.analog_c : '0;
      ang[0] = enc_en[0] ? 32'(req.angle_a) : '0;
      ang[1] = enc_en[1] ? 32'(req.angle_b) : '0;
      dl[0]  = enc_en[0] ? ang[0] - sent_angles_ff[0] : '0;
      dl[1]  = enc_en[1] ? ang[1] - sent_angles_ff[1] : '0;
   end

   // change against the last sent report
   always_comb begin
      send = (held != sent_buttons_ff);
      for (int i = 0; i < 3; i++) begin
         if (an_en[i] && (an[i] != sent_analogs_ff[i])) begin
            send = 1'b1;
         end
      end
      for (int i = 0; i < 2; i++) begin
         if (enc_en[i] && (dl[i] != '0)) begin
            send = 1'b1;
         end
      end
   end

   // result beat contents
   always_comb begin
      rsp.send_now     = send;
      rsp.buttons_held = held;
      rsp.analog_out_a = an[0];
      rsp.analog_out_b = an[1];
      rsp.analog_out_c = an[2];
      rsp.angle_out_a  = ang[0];
      rsp.angle_out_b  = ang[1];
      rsp.delta_out_a  = dl[0];
      rsp.delta_out_b  = dl[1];
   end

   // last sent store update
   always_comb begin
      sent_buttons_in = sent_buttons_ff;
      sent_analogs_in = sent_analogs_ff;
      sent_angles_in  = sent_angles_ff;
      if (advance && send) begin
         sent_buttons_in = held;
         sent_analogs_in = an;
         sent_angles_in  = ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_buttons_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sent_analogs_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            sent_angles_ff[i] <= '0;
         end
      end else begin
         sent_buttons_ff <= sent_buttons_in;
         sent_analogs_ff <= sent_analogs_in;
         sent_angles_ff  <= sent_angles_in;
      end
   end

   `AST_CLK(a_sent_update, clock, reset, (advance && send) |=> sent_buttons_ff == $past(held))
   `AST_CLK(a_sent_hold, clock, reset, !(advance && send) |=> $stable(sent_buttons_ff))
   `AST_NEVER(a_delta_off, clock, reset, !enc_en[0] && (rsp.delta_out_a != '0))

endmodule

// File: sv/input_debounce_change_reporter_top.sv
// order: a request beat enters the input register, then the result register
// throughput: one request beat per clock while rsp_ready is high; the input and
//   result registers are separate stages; last-sent store updates in the same cycle
// reset: synchronous, active high; clears the debounce ring, write slot,
//   last-sent report, counts and both valid flags
`include "input_debounce_change_reporter_top_assert.svh"

module input_debounce_change_reporter_top
   import idcr_pkg::*;
#(
   parameter int DEBOUNCE_DEPTH = DEBOUNCE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_next;
   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    out_open;
   logic    advance;
   logic    csr_wr;
   logic [20:0] held;

   // handshake between the two stages
   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_open;
   assign req_ready = !in_valid_ff || out_open;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // csr writes and reads
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (paddr[2])
            CSR_IDX_ANALOG:  cfg_in.analog_count  = pwdata[1:0];
            CSR_IDX_ENCODER: cfg_in.encoder_count = pwdata[1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_IDX_ANALOG:  prdata = {(CSR_DATA_W - 2)'(0), cfg_ff.analog_count};
         CSR_IDX_ENCODER: prdata = {(CSR_DATA_W - 2)'(0), cfg_ff.encoder_count};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   idcr_ring #(
      .DEBOUNCE_DEPTH (DEBOUNCE_DEPTH)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .pin_levels (in_data_ff.pin_levels),
      .held       (held)
   );

   idcr_report u_report (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg_ff),
      .req     (in_data_ff),
      .held    (held),
      .rsp     (rsp_next)
   );

endmodule

// File: tb/sv/tb_input_debounce_change_reporter_top.sv
`timescale 1ns / 1ps

module tb_input_debounce_change_reporter_top
   import idcr_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int REQ_W = $bits(req_type);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   input_debounce_change_reporter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // polls waiting to be driven and reports waiting to be seen
   req_type pending_polls[$];
   rsp_type expected_reports[$];

   // shadow copy of the block state
   logic [20:0] shadow_ring [DEBOUNCE_DEPTH_DEF];
   int          shadow_slot;
   logic [20:0] last_buttons;
   logic [11:0] last_analogs [3];
   logic [31:0] last_angles [2];
   logic [1:0]  analog_cnt;
   logic [1:0]  encoder_cnt;

   logic    gaps_on = 1'b1;
   int      failures = 0;
   int      polls_done = 0;
   int      sends_seen = 0;
   int      settings_done = 0;
   int      cycles = 0;
   req_type poll_now;

   initial begin
      for (int i = 0; i < DEBOUNCE_DEPTH_DEF; i++) shadow_ring[i] = '0;
      shadow_slot = 0;
      last_buttons = '0;
      for (int i = 0; i < 3; i++) last_analogs[i] = '0;
      last_angles[0] = '0;
      last_angles[1] = '0;
      analog_cnt = '0;
      encoder_cnt = '0;
   end

   // debounce the buttons and decide whether this poll makes a report
   function automatic rsp_type debounce_report(req_type poll);
      rsp_type     rep;
      logic [20:0] held;
      logic [11:0] an [3];
      logic [31:0] ang [2];
      logic [31:0] dl [2];
      int          n_enc;
      logic        send;
      shadow_ring[shadow_slot] = ~poll.pin_levels & BUTTON_MASK;
      shadow_slot = (shadow_slot + 1) % DEBOUNCE_DEPTH_DEF;
      held = '0;
      for (int i = 0; i < DEBOUNCE_DEPTH_DEF; i++) held |= shadow_ring[i];
      held &= BUTTON_MASK;
      n_enc = (encoder_cnt > 2) ? 2 : int'(encoder_cnt);
      an[0] = (analog_cnt > 0) ? poll.analog_a : 12'd0;
      an[1] = (analog_cnt > 1) ? poll.analog_b : 12'd0;
      an[2] = (analog_cnt > 2) ? poll.analog_c : 12'd0;
      ang[0] = (n_enc > 0) ? poll.angle_a : 32'd0;
      ang[1] = (n_enc > 1) ? poll.angle_b : 32'd0;
      for (int i = 0; i < 2; i++) dl[i] = (i < n_enc) ? ang[i] - last_angles[i] : 32'd0;
      // compare only enabled channels against the last sent report
      send = (held != last_buttons);
      for (int i = 0; i < analog_cnt; i++)
         if (an[i] != last_analogs[i]) send = 1'b1;
      for (int i = 0; i < n_enc; i++)
         if (ang[i] != last_angles[i] || dl[i] != 0) send = 1'b1;
      if (send) begin
         last_buttons = held;
         for (int i = 0; i < 3; i++) last_analogs[i] = an[i];
         last_angles[0] = ang[0];
         last_angles[1] = ang[1];
      end
      rep.send_now     = send;
      rep.buttons_held = held;
      rep.analog_out_a = an[0];
      rep.analog_out_b = an[1];
      rep.analog_out_c = an[2];
      rep.angle_out_a  = ang[0];
      rep.angle_out_b  = ang[1];
      rep.delta_out_a  = dl[0];
      rep.delta_out_b  = dl[1];
      return rep;
   endfunction

   task automatic note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) note_failure($sformatf("%s expected %h got %h", name, want, got));
   endtask

   // poll driver: holds each beat until it is taken
   always @(posedge clock) begin : poll_driver
      logic taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            expected_reports.push_back(debounce_report(req_data));
            polls_done++;
            void'(pending_polls.pop_front());
         end
         if (req_valid && !taken) begin
            // hold the current beat
         end else if (pending_polls.size() != 0 && !(gaps_on && $urandom_range(99) < 7)) begin
            req_valid <= 1'b1;
            req_data  <= pending_polls[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // report monitor with random back-pressure
   always @(posedge clock) begin : report_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               note_failure("report beat with nothing expected");
            end else begin
               want = expected_reports.pop_front();
               if (rsp_data.send_now) sends_seen++;
               field_check("send_now", 32'(want.send_now), 32'(rsp_data.send_now));
               field_check("buttons_held", 32'(want.buttons_held), 32'(rsp_data.buttons_held));
               field_check("analog_out_a", 32'(want.analog_out_a), 32'(rsp_data.analog_out_a));
               field_check("analog_out_b", 32'(want.analog_out_b), 32'(rsp_data.analog_out_b));
               field_check("analog_out_c", 32'(want.analog_out_c), 32'(rsp_data.analog_out_c));
               field_check("angle_out_a", want.angle_out_a, rsp_data.angle_out_a);
               field_check("angle_out_b", want.angle_out_b, rsp_data.angle_out_b);
               field_check("delta_out_a", want.delta_out_a, rsp_data.delta_out_a);
               field_check("delta_out_b", want.delta_out_b, rsp_data.delta_out_b);
            end
         end
         rsp_ready <= !(gaps_on && $urandom_range(99) < 7);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // apb write: setup cycle, then access cycle
   task automatic count_write(logic [0:0] idx, logic [1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= ($urandom() & 32'hFFFF_FFFC) | 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (idx == CSR_IDX_ANALOG) analog_cnt = value;
      else encoder_cnt = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_polls.size() != 0 || expected_reports.size() != 0 || req_valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_counts(logic [1:0] n_analog, logic [1:0] n_encoder);
      wait_idle();
      count_write(CSR_IDX_ANALOG, n_analog);
      count_write(CSR_IDX_ENCODER, n_encoder);
      settings_done++;
   endtask

   task automatic put_poll(logic [20:0] pins, logic [11:0] a0, logic [11:0] a1,
                           logic [11:0] a2, logic [31:0] e0, logic [31:0] e1);
      poll_now.pin_levels = pins;
      poll_now.analog_a   = a0;
      poll_now.analog_b   = a1;
      poll_now.analog_c   = a2;
      poll_now.angle_a    = e0;
      poll_now.angle_b    = e1;
      pending_polls.push_back(poll_now);
   endtask

   function automatic logic [11:0] drift_analog(logic [11:0] v);
      int pick;
      pick = $urandom_range(99);
      if (pick < 80) return v;
      if (pick < 95) return v + 12'($urandom_range(8)) - 12'd4;
      if (pick < 97) return (pick[0]) ? 12'hFFF : 12'h000;
      return 12'($urandom());
   endfunction

   function automatic logic [31:0] drift_angle(logic [31:0] v);
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) return v;
      if (pick < 95) return v + $urandom_range(200) - 100;
      if (pick == 95) return 32'h7FFF_FFFF;
      if (pick == 96) return 32'h8000_0000;
      return $urandom();
   endfunction

   // random polls: mostly a slowly moving panel, some pure noise
   task automatic queue_polls(int count);
      int pick;
      int b;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 10) begin
            poll_now = REQ_W'({$urandom(), $urandom(), $urandom(), $urandom()});
         end else begin
            pick = $urandom_range(99);
            if (pick < 12) begin
               poll_now.pin_levels = {1'b1, 4'($urandom()), 16'hFFFF};
            end else if (pick < 28) begin
               b = $urandom_range(16);
               if (b == 16) b = 20;
               poll_now.pin_levels[b] = ~poll_now.pin_levels[b];
            end else if (pick < 32) begin
               poll_now.pin_levels = 21'($urandom());
            end
            poll_now.analog_a = drift_analog(poll_now.analog_a);
            poll_now.analog_b = drift_analog(poll_now.analog_b);
            poll_now.analog_c = drift_analog(poll_now.analog_c);
            poll_now.angle_a  = drift_angle(poll_now.angle_a);
            poll_now.angle_b  = drift_angle(poll_now.angle_b);
         end
         pending_polls.push_back(poll_now);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // buttons only: press passes at once, release held for a full ring
      set_counts(2'd0, 2'd0);
      put_poll(21'h1FFFFF, 12'h000, 12'h000, 12'h000, 32'h0, 32'h0);
      put_poll(21'h000000, 12'hFFF, 12'hFFF, 12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      repeat (6) put_poll(21'h1FFFFF, 12'h000, 12'h000, 12'h000, 32'h0, 32'h0);
      put_poll(21'h0F0000, 12'h123, 12'h456, 12'h789, 32'h1, 32'h2);

      // all channels, encoder count of three saturates to two
      set_counts(2'd3, 2'd3);
      put_poll(21'h1FFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      put_poll(21'h1FFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      // angle wraps from max to min
      put_poll(21'h1FFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      put_poll(21'h1FFFFF, 12'h000, 12'h000, 12'h000, 32'h8000_0000, 32'h7FFF_FFFF);
      put_poll(21'h1FFFFF, 12'h000, 12'h000, 12'h000, 32'h8000_0000, 32'h7FFF_FFFF);

      // count change between sends, disabled channels ignored
      set_counts(2'd1, 2'd1);
      put_poll(21'h1FFFFF, 12'h000, 12'h000, 12'h000, 32'h8000_0000, 32'h7FFF_FFFF);
      put_poll(21'h1FFFFF, 12'h000, 12'hABC, 12'h000, 32'h8000_0000, 32'h7FFF_FFFF);
      put_poll(21'h1FFFFF, 12'h000, 12'hABC, 12'h000, 32'h8000_0000, 32'h0000_1234);
      put_poll(21'h0FFFFF, 12'h000, 12'hABC, 12'h000, 32'h8000_0000, 32'h0000_1234);
      put_poll(21'h1FFFFE, 12'h000, 12'hABC, 12'h555, 32'h8000_0000, 32'h0000_1234);
      put_poll(21'h1FFFFE, 12'hAAA, 12'hABC, 12'h555, 32'hFFFF_FFFF, 32'h0000_1234);

      // random phases across the count settings
      set_counts(2'd3, 2'd2);
      queue_polls(210);
      set_counts(2'd1, 2'd1);
      queue_polls(210);
      set_counts(2'd0, 2'd0);
      queue_polls(210);
      set_counts(2'd2, 2'd3);
      wait_idle();
      gaps_on = 1'b0;
      queue_polls(210);
      wait_idle();
      gaps_on = 1'b1;
      set_counts(2'd3, 2'd1);
      queue_polls(210);
      set_counts(2'd0, 2'd2);
      queue_polls(210);

      wait_idle();
      repeat (10) @(posedge clock);
      if (expected_reports.size() != 0) note_failure("reports still outstanding at end");
      $display("ran %0d polls over %0d count settings, %0d of them raised a report",
               polls_done, settings_done, sends_seen);
      $display("%0d failures counted", failures);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
